>>> src/hsa_pkg.sv
// hsa_pkg: shared constants, types and codes for the handle slot allocator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package hsa_pkg;

  localparam int SLOTS    = 64;
  localparam int RESERVED = 4;
  localparam int KEY_BITS = 32;

  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CAP_W    = 7;
  localparam int HANDLE_W = 32;
  localparam int RS_W     = 2;
  localparam int FUNC_W   = 2;
  localparam int CMP_W    = (CAP_W > SLOT_W + 1) ? CAP_W : SLOT_W + 1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [SLOT_W-1:0]   slot_idx_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_FIND_ADD = 2'd0,
    FN_ADD_RES  = 2'd1,
    FN_REMOVE   = 2'd2,
    FN_FIND     = 2'd3
  } func_t;

  // write request into the key store
  typedef struct packed {
    logic      en;
    slot_idx_t addr;
    key_t      key;
  } key_wr_t;

endpackage

>>> src/hsa_key_store.sv
// hsa_key_store: key memory with one registered read port and the shared key comparator
// depends on hsa_pkg
`timescale 1ns / 1ps

module hsa_key_store (
  input  logic             clk,
  input  hsa_pkg::slot_idx_t rd_addr,
  input  hsa_pkg::key_t    cmp_key,
  input  hsa_pkg::key_wr_t wr,
  output logic             key_eq
);
  import hsa_pkg::*;

  key_t mem [SLOTS];
  key_t rd_key;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.key;
    end
    rd_key <= mem[rd_addr];
  end

  // compare the key read last cycle against the key of the item
  assign key_eq = (rd_key == cmp_key);

endmodule

>>> src/handle_slot_allocator.sv
// handle_slot_allocator: top level, sequencer, used and mapped marks, result register
// depends on hsa_pkg and hsa_key_store
`timescale 1ns / 1ps

// Maps handle keys to slots. An item is taken when start is high and busy is low; its result
// shows on slot, hit, was_new and full_res for the one cycle in which done is high, and it
// cannot be held off. Each item walks the key memory one slot per cycle through a single
// read port and comparator, looking for the handle and the lowest free slot in the same pass,
// then goes through the drain and commit states before done rises. busy is low again in the
// strobe cycle, so the next item may be taken at the edge that ends it. capacity may be
// written only while busy is low and no strobe is pending.

module handle_slot_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [hsa_pkg::FUNC_W-1:0]    func,
  input  logic [hsa_pkg::HANDLE_W-1:0]  handle,
  input  logic [hsa_pkg::RS_W-1:0]      reserved_slot,
  input  logic                          cfg_wr_en,
  input  logic [hsa_pkg::CAP_W-1:0]     cfg_wr_data,
  output logic                          done,
  output logic [hsa_pkg::SLOT_W-1:0]    slot,
  output logic                          hit,
  output logic                          was_new,
  output logic                          full_res
);
  import hsa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  state_t          state;
  logic [CAP_W-1:0] capacity;
  func_t           op;
  key_t            key;
  logic [RS_W-1:0] rs;
  slot_idx_t       idx;
  slot_idx_t       cmp_idx;
  logic            cmp_vld;
  logic            found;
  slot_idx_t       found_idx;
  logic            free_found;
  slot_idx_t       free_idx;
  logic [SLOTS-1:0] used;
  logic [SLOTS-1:0] mapped;

  logic            key_eq;
  logic            match;
  logic            free_here;
  key_wr_t         wr;
  logic            set_en;
  slot_idx_t       set_idx;
  logic            clr_en;
  slot_idx_t       res_slot;
  logic            res_hit;
  logic            res_new;
  logic            res_full;
  logic            rs_ok;

  hsa_key_store u_key_store (
    .clk     (clk),
    .rd_addr (idx),
    .cmp_key (key),
    .wr      (wr),
    .key_eq  (key_eq)
  );

  assign busy  = (state != ST_IDLE);
  assign match = cmp_vld && mapped[cmp_idx] && key_eq && !found;

  // lowest slot below capacity whose used mark is clear
  assign free_here = (state == ST_SCAN) && !free_found && !used[idx] &&
                     (CMP_W'(idx) < CMP_W'(capacity));

  assign rs_ok = (CMP_W'(rs) < CMP_W'(RESERVED));

  always_comb begin
    wr       = '0;
    wr.key   = key;
    set_en   = 1'b0;
    set_idx  = '0;
    clr_en   = 1'b0;
    res_slot = found ? found_idx : '0;
    res_hit  = found;
    res_new  = 1'b0;
    res_full = 1'b0;
    unique case (op)
      FN_FIND_ADD: begin
        if (!found) begin
          if (free_found) begin
            set_en   = 1'b1;
            set_idx  = free_idx;
            res_slot = free_idx;
            res_new  = 1'b1;
          end else begin
            res_full = 1'b1;
          end
        end
      end
      FN_ADD_RES: begin
        if (!found && rs_ok) begin
          set_en   = 1'b1;
          set_idx  = SLOT_W'(rs);
          res_slot = SLOT_W'(rs);
        end
      end
      FN_REMOVE: begin
        clr_en = found;
      end
      FN_FIND: begin
      end
      default: begin
      end
    endcase
    wr.en   = set_en && (state == ST_COMMIT);
    wr.addr = set_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      capacity <= CAP_RESET;
      done     <= 1'b0;
      cmp_vld  <= 1'b0;
      mapped   <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        used[i] <= (i < RESERVED);
      end
    end else begin
      done <= 1'b0;
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      cmp_vld <= (state == ST_SCAN);
      cmp_idx <= idx;
      if (match) begin
        found     <= 1'b1;
        found_idx <= cmp_idx;
      end
      if (free_here) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op         <= func_t'(func);
            key        <= KEY_BITS'(handle);
            rs         <= reserved_slot;
            idx        <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx == SLOT_W'(SLOTS - 1)) begin
            state <= ST_DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (set_en) begin
            used[set_idx]   <= 1'b1;
            mapped[set_idx] <= 1'b1;
          end
          if (clr_en) begin
            used[found_idx]   <= 1'b0;
            mapped[found_idx] <= 1'b0;
          end
          slot     <= res_slot;
          hit      <= res_hit;
          was_new  <= res_new;
          full_res <= res_full;
          done     <= 1'b1;
          state    <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/hsa_checker.sv
// hsa_checker: port-level assertions for handle_slot_allocator, bound to the top level
// depends on hsa_pkg
`timescale 1ns / 1ps

module hsa_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [hsa_pkg::SLOT_W-1:0] slot,
  input logic                       hit,
  input logic                       was_new,
  input logic                       full_res
);
  import hsa_pkg::*;

  // an accepted item keeps the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low after item accepted");

  // the strobe comes only once the scan is over
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_new_or_full: assert property (@(posedge clk) disable iff (rst)
    done |-> !(was_new && full_res) && !(was_new && hit))
    else $error("inconsistent result flags");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    done && full_res |-> (slot == '0) && !hit)
    else $error("full result carries a slot");

  // one strobe per item, never two in a row
  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back to back result strobes");

endmodule

bind handle_slot_allocator hsa_checker u_hsa_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .slot     (slot),
  .hit      (hit),
  .was_new  (was_new),
  .full_res (full_res)
);
